/* sv/tta_pkg.sv */
`default_nettype none
package tta_pkg;

	// Field widths.
	localparam int AXIS_BITS = 16;
	localparam int GAIN_BITS = 16;
	localparam int GAIN_FRAC = 12;
	localparam int DEAD_BITS = AXIS_BITS - 1;
	localparam int PWM_BITS  = 12;

	// Datapath widths.
	localparam int PROD_BITS = AXIS_BITS + GAIN_BITS;
	localparam int SUM_BITS  = PROD_BITS + 2;
	localparam int MAG_BITS  = PROD_BITS;
	localparam int NUM_BITS  = PWM_BITS + MAG_BITS;
	localparam int REM_BITS  = NUM_BITS + 2;
	localparam int DIV_BITS  = MAG_BITS + 1;
	localparam int Q_BITS    = PWM_BITS;
	localparam int LANES     = 3;

	// Full scale, 1.0 at the scale of the mixed thrust.
	localparam logic [MAG_BITS-1:0] UNIT =
		{{(MAG_BITS - AXIS_BITS - GAIN_FRAC){1'b0}}, 1'b1, {(AXIS_BITS - 1 + GAIN_FRAC){1'b0}}};

	// Saturation limit of a PWM value.
	localparam logic [PWM_BITS-1:0] PWM_MAX = {PWM_BITS{1'b1}};

	// Register file.
	localparam int DATA_BITS    = 32;
	localparam int ADDR_BITS    = 5;
	localparam int REG_IDX_BITS = 3;

	localparam logic [REG_IDX_BITS-1:0] REG_SURGE_GAIN_FIRST  = 3'd0;
	localparam logic [REG_IDX_BITS-1:0] REG_SURGE_GAIN_SECOND = 3'd1;
	localparam logic [REG_IDX_BITS-1:0] REG_SWAY_GAIN         = 3'd2;
	localparam logic [REG_IDX_BITS-1:0] REG_YAW_GAIN          = 3'd3;
	localparam logic [REG_IDX_BITS-1:0] REG_DEAD_BAND         = 3'd4;
	localparam logic [REG_IDX_BITS-1:0] REG_PWM_CENTER        = 3'd5;
	localparam logic [REG_IDX_BITS-1:0] REG_PWM_FORWARD_SPAN  = 3'd6;
	localparam logic [REG_IDX_BITS-1:0] REG_PWM_REVERSE_SPAN  = 3'd7;

	// Reset values of the registers.
	localparam logic [GAIN_BITS-1:0] RST_SURGE_GAIN_FIRST  = 16'sd4096;
	localparam logic [GAIN_BITS-1:0] RST_SURGE_GAIN_SECOND = 16'sd4096;
	localparam logic [GAIN_BITS-1:0] RST_SWAY_GAIN         = -16'sd3251;
	localparam logic [GAIN_BITS-1:0] RST_YAW_GAIN          = 16'sd4334;
	localparam logic [DEAD_BITS-1:0] RST_DEAD_BAND         = 15'd1638;
	localparam logic [PWM_BITS-1:0]  RST_PWM_CENTER        = 12'd1500;
	localparam logic [PWM_BITS-1:0]  RST_PWM_FORWARD_SPAN  = 12'd400;
	localparam logic [PWM_BITS-1:0]  RST_PWM_REVERSE_SPAN  = 12'd200;

	// Configuration as seen by the datapath.
	typedef struct packed {
		logic signed [GAIN_BITS-1:0] surge_gain_first;
		logic signed [GAIN_BITS-1:0] surge_gain_second;
		logic signed [GAIN_BITS-1:0] sway_gain;
		logic signed [GAIN_BITS-1:0] yaw_gain;
		logic [DEAD_BITS-1:0]        dead_band;
		logic [PWM_BITS-1:0]         pwm_center;
		logic [PWM_BITS-1:0]         pwm_forward_span;
		logic [PWM_BITS-1:0]         pwm_reverse_span;
	} cfg_t;

	// Mixed thrust of the three thrusters.
	typedef struct packed {
		logic signed [SUM_BITS-1:0] t1;
		logic signed [SUM_BITS-1:0] t2;
		logic signed [SUM_BITS-1:0] t3;
	} thrust_t;

	// One lane of the quotient pipeline.
	typedef struct packed {
		logic [REM_BITS-1:0] rem;
		logic [DIV_BITS-1:0] dvs;
		logic [Q_BITS-1:0]   quo;
		logic                neg;
	} div_lane_t;

	typedef div_lane_t [LANES-1:0] div_vec_t;

	// Sign extension of a product to the sum width.
	function automatic logic signed [SUM_BITS-1:0] ext_prod(input logic signed [PROD_BITS-1:0] p);
		return {{(SUM_BITS - PROD_BITS){p[PROD_BITS-1]}}, p};
	endfunction

endpackage
`default_nettype wire

/* sv/tta_front.sv */
`default_nettype none
module tta_front (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                en,
	input  wire tta_pkg::cfg_t                       cfg,
	input  wire logic                                valid_in,
	input  wire logic signed [tta_pkg::AXIS_BITS-1:0] surge_in,
	input  wire logic signed [tta_pkg::AXIS_BITS-1:0] sway_in,
	input  wire logic signed [tta_pkg::AXIS_BITS-1:0] yaw_in,
	output logic                                     valid_out,
	output tta_pkg::thrust_t                         thrust_out
);

	logic                                 valid_s1, valid_s2, valid_s3, valid_s4;
	logic signed [tta_pkg::AXIS_BITS-1:0] surge_s1, sway_s1, yaw_s1;
	logic signed [tta_pkg::AXIS_BITS-1:0] surge_d, sway_d, yaw_d;
	logic signed [tta_pkg::PROD_BITS-1:0] p1_s2, p2_s2, psw_s2, pyw_s2;
	logic signed [tta_pkg::AXIS_BITS-1:0] sway_s2;
	logic signed [tta_pkg::PROD_BITS-1:0] p1_s3, p2_s3;
	logic signed [tta_pkg::SUM_BITS-1:0]  mix_s3;
	logic signed [tta_pkg::AXIS_BITS-1:0] sway_s3;
	tta_pkg::thrust_t                     thrust_s4;

	// Zero an axis whose magnitude is at or below the dead band.
	function automatic logic signed [tta_pkg::AXIS_BITS-1:0] dead_zone(
		input logic signed [tta_pkg::AXIS_BITS-1:0] a,
		input logic [tta_pkg::DEAD_BITS-1:0]        band
	);
		logic [tta_pkg::AXIS_BITS-1:0] m;
		m = a[tta_pkg::AXIS_BITS-1] ? ({tta_pkg::AXIS_BITS{1'b0}} - a) : a;
		return (m <= {1'b0, band}) ? {tta_pkg::AXIS_BITS{1'b0}} : a;
	endfunction

	always_comb begin
		surge_d = dead_zone(surge_in, cfg.dead_band);
		sway_d  = dead_zone(sway_in, cfg.dead_band);
		yaw_d   = dead_zone(yaw_in, cfg.dead_band);
	end

	// Valid bits of the four stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_in;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// Stage 1 holds the axes after the dead band, stage 2 the gain products,
	// stage 3 the shared sway and yaw term, stage 4 the thruster sums.
	always_ff @(posedge clk) begin
		if (en) begin
			surge_s1 <= surge_d;
			sway_s1  <= sway_d;
			yaw_s1   <= yaw_d;

			p1_s2   <= $signed(surge_s1) * $signed(cfg.surge_gain_first);
			p2_s2   <= $signed(surge_s1) * $signed(cfg.surge_gain_second);
			psw_s2  <= $signed(sway_s1) * $signed(cfg.sway_gain);
			pyw_s2  <= $signed(yaw_s1) * $signed(cfg.yaw_gain);
			sway_s2 <= sway_s1;

			p1_s3   <= p1_s2;
			p2_s3   <= p2_s2;
			mix_s3  <= tta_pkg::ext_prod(psw_s2) + tta_pkg::ext_prod(pyw_s2);
			sway_s3 <= sway_s2;

			thrust_s4.t1 <= tta_pkg::ext_prod(p1_s3) + mix_s3;
			thrust_s4.t2 <= tta_pkg::ext_prod(p2_s3) - mix_s3;
			thrust_s4.t3 <= {{(tta_pkg::SUM_BITS - tta_pkg::AXIS_BITS - tta_pkg::GAIN_FRAC)
				{sway_s3[tta_pkg::AXIS_BITS-1]}}, sway_s3, {tta_pkg::GAIN_FRAC{1'b0}}};
		end
	end

	assign valid_out  = valid_s4;
	assign thrust_out = thrust_s4;

endmodule
`default_nettype wire

/* sv/tta_scale.sv */
`default_nettype none
module tta_scale (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire tta_pkg::cfg_t    cfg,
	input  wire logic             valid_in,
	input  wire tta_pkg::thrust_t thrust_in,
	output logic                  valid_out,
	output tta_pkg::div_vec_t     lanes_out
);

	logic                                 valid_s5, valid_s6, valid_s7;
	logic signed [tta_pkg::SUM_BITS-1:0]  t_d [tta_pkg::LANES];
	logic [tta_pkg::MAG_BITS-1:0]         mag_s5 [tta_pkg::LANES];
	logic [tta_pkg::PWM_BITS-1:0]         span_s5 [tta_pkg::LANES];
	logic                                 neg_s5 [tta_pkg::LANES];
	logic [tta_pkg::NUM_BITS-1:0]         num_s6 [tta_pkg::LANES];
	logic [tta_pkg::MAG_BITS-1:0]         den_s6;
	logic                                 neg_s6 [tta_pkg::LANES];
	tta_pkg::div_vec_t                    lanes_s7;
	logic [tta_pkg::MAG_BITS-1:0]         max_a, max_b, den_d;

	assign t_d[0] = thrust_in.t1;
	assign t_d[1] = thrust_in.t2;
	assign t_d[2] = thrust_in.t3;

	// The divisor is the largest magnitude, but never below full scale.
	always_comb begin
		max_a = (mag_s5[0] > mag_s5[1]) ? mag_s5[0] : mag_s5[1];
		max_b = (mag_s5[2] > tta_pkg::UNIT) ? mag_s5[2] : tta_pkg::UNIT;
		den_d = (max_a > max_b) ? max_a : max_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else if (en) begin
			valid_s5 <= valid_in;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
		end
	end

	// Stage 5 splits sign and magnitude and picks the span, stage 6 forms the
	// scaled numerator and the divisor, stage 7 sets up the rounded quotient.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < tta_pkg::LANES; l++) begin
				neg_s5[l]  <= t_d[l][tta_pkg::SUM_BITS-1];
				mag_s5[l]  <= t_d[l][tta_pkg::SUM_BITS-1] ?
					tta_pkg::MAG_BITS'(-t_d[l]) : t_d[l][tta_pkg::MAG_BITS-1:0];
				span_s5[l] <= t_d[l][tta_pkg::SUM_BITS-1] ?
					cfg.pwm_reverse_span : cfg.pwm_forward_span;

				num_s6[l] <= {{(tta_pkg::NUM_BITS - tta_pkg::PWM_BITS){1'b0}}, span_s5[l]} *
					{{(tta_pkg::NUM_BITS - tta_pkg::MAG_BITS){1'b0}}, mag_s5[l]};
				neg_s6[l] <= neg_s5[l];

				lanes_s7[l].rem <= {1'b0, num_s6[l], 1'b0} +
					{{(tta_pkg::REM_BITS - tta_pkg::MAG_BITS){1'b0}}, den_s6};
				lanes_s7[l].dvs <= {den_s6, 1'b0};
				lanes_s7[l].quo <= {tta_pkg::Q_BITS{1'b0}};
				lanes_s7[l].neg <= neg_s6[l];
			end
			den_s6 <= den_d;
		end
	end

	assign valid_out = valid_s7;
	assign lanes_out = lanes_s7;

endmodule
`default_nettype wire

/* sv/tta_div.sv */
`default_nettype none
module tta_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              valid_in,
	input  wire tta_pkg::div_vec_t lanes_in,
	output logic                   valid_out,
	output tta_pkg::div_vec_t      lanes_out
);

	// One quotient bit per stage, most significant first.
	tta_pkg::div_vec_t lane_s  [tta_pkg::Q_BITS];
	logic              valid_s [tta_pkg::Q_BITS];

	for (genvar k = 0; k < tta_pkg::Q_BITS; k++) begin : g_stage
		localparam int BIT = tta_pkg::Q_BITS - 1 - k;

		tta_pkg::div_vec_t src;
		tta_pkg::div_vec_t nxt;
		logic              src_valid;

		if (k == 0) begin : g_first
			assign src       = lanes_in;
			assign src_valid = valid_in;
		end else begin : g_next
			assign src       = lane_s[k-1];
			assign src_valid = valid_s[k-1];
		end

		// Subtract the shifted divisor where it fits and set the quotient bit.
		always_comb begin
			logic [tta_pkg::REM_BITS-1:0] shifted;
			logic [tta_pkg::REM_BITS:0]   diff;
			nxt = src;
			for (int l = 0; l < tta_pkg::LANES; l++) begin
				shifted = {{(tta_pkg::REM_BITS - tta_pkg::DIV_BITS){1'b0}}, src[l].dvs} << BIT;
				diff    = {1'b0, src[l].rem} - {1'b0, shifted};
				if (!diff[tta_pkg::REM_BITS]) begin
					nxt[l].rem      = diff[tta_pkg::REM_BITS-1:0];
					nxt[l].quo[BIT] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (en) begin
				valid_s[k] <= src_valid;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				lane_s[k] <= nxt;
			end
		end
	end

	assign valid_out = valid_s[tta_pkg::Q_BITS-1];
	assign lanes_out = lane_s[tta_pkg::Q_BITS-1];

endmodule
`default_nettype wire

/* sv/three_thruster_allocation_pwm.sv */
// Three-thruster allocation with PWM output.
// The sample channel (sample_valid, sample_stall) takes one joystick beat of
// surge, sway and yaw in signed Q1.15. The pwm channel (pwm_valid, pwm_stall)
// returns one beat of three 12-bit PWM values for each sample, in order.
// Axes inside the dead band are zeroed, mixed with the gain registers,
// normalized by the largest thrust when it exceeds full scale, and mapped
// around the PWM center with rounding half away from zero and saturation.
// Throughput is one beat per cycle while the receiver does not stall. A beat
// accepted passes the front stages, the scale stages, the twelve-stage quotient
// pipeline, one bit per stage, and the output register before it is on the outputs.
// When the receiver stalls while a result waits, the whole pipeline holds
// and sample_stall rises in the same cycle; nothing is dropped or repeated.
// Registers sit on an APB port at byte address 4*index; the user must see
// that they are written only while the pipeline is empty, as the block does
// not enforce it. Reset clears all valid bits and loads the register defaults.
`default_nettype none
module three_thruster_allocation_pwm (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 psel,
	input  wire logic                                 penable,
	input  wire logic                                 pwrite,
	input  wire logic [tta_pkg::ADDR_BITS-1:0]        paddr,
	input  wire logic [tta_pkg::DATA_BITS-1:0]        pwdata,
	output logic [tta_pkg::DATA_BITS-1:0]             prdata,
	output logic                                      pready,
	input  wire logic                                 sample_valid,
	output logic                                      sample_stall,
	input  wire logic signed [tta_pkg::AXIS_BITS-1:0] surge_axis,
	input  wire logic signed [tta_pkg::AXIS_BITS-1:0] sway_axis,
	input  wire logic signed [tta_pkg::AXIS_BITS-1:0] yaw_axis,
	output logic                                      pwm_valid,
	input  wire logic                                 pwm_stall,
	output logic [tta_pkg::PWM_BITS-1:0]              pwm_one,
	output logic [tta_pkg::PWM_BITS-1:0]              pwm_two,
	output logic [tta_pkg::PWM_BITS-1:0]              pwm_three
);

	tta_pkg::cfg_t                        cfg_q;
	logic [tta_pkg::REG_IDX_BITS-1:0]     reg_idx;
	logic                                 cfg_wr;
	logic                                 en;
	logic                                 front_valid, scale_valid, div_valid;
	tta_pkg::thrust_t                     thrust;
	tta_pkg::div_vec_t                    scale_lanes, div_lanes;
	logic [tta_pkg::PWM_BITS-1:0]         pwm_d [tta_pkg::LANES];
	logic [tta_pkg::PWM_BITS:0]           pwm_sum [tta_pkg::LANES];
	logic                                 out_valid_q;
	logic [tta_pkg::PWM_BITS-1:0]         pwm_q [tta_pkg::LANES];

	// Register port.
	assign pready  = 1'b1;
	assign reg_idx = paddr[tta_pkg::ADDR_BITS-1:tta_pkg::ADDR_BITS-tta_pkg::REG_IDX_BITS];
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.surge_gain_first  <= tta_pkg::RST_SURGE_GAIN_FIRST;
			cfg_q.surge_gain_second <= tta_pkg::RST_SURGE_GAIN_SECOND;
			cfg_q.sway_gain         <= tta_pkg::RST_SWAY_GAIN;
			cfg_q.yaw_gain          <= tta_pkg::RST_YAW_GAIN;
			cfg_q.dead_band         <= tta_pkg::RST_DEAD_BAND;
			cfg_q.pwm_center        <= tta_pkg::RST_PWM_CENTER;
			cfg_q.pwm_forward_span  <= tta_pkg::RST_PWM_FORWARD_SPAN;
			cfg_q.pwm_reverse_span  <= tta_pkg::RST_PWM_REVERSE_SPAN;
		end else if (cfg_wr) begin
			case (reg_idx)
				tta_pkg::REG_SURGE_GAIN_FIRST: begin
					cfg_q.surge_gain_first <= pwdata[tta_pkg::GAIN_BITS-1:0];
				end
				tta_pkg::REG_SURGE_GAIN_SECOND: begin
					cfg_q.surge_gain_second <= pwdata[tta_pkg::GAIN_BITS-1:0];
				end
				tta_pkg::REG_SWAY_GAIN: begin
					cfg_q.sway_gain <= pwdata[tta_pkg::GAIN_BITS-1:0];
				end
				tta_pkg::REG_YAW_GAIN: begin
					cfg_q.yaw_gain <= pwdata[tta_pkg::GAIN_BITS-1:0];
				end
				tta_pkg::REG_DEAD_BAND: begin
					cfg_q.dead_band <= pwdata[tta_pkg::DEAD_BITS-1:0];
				end
				tta_pkg::REG_PWM_CENTER: begin
					cfg_q.pwm_center <= pwdata[tta_pkg::PWM_BITS-1:0];
				end
				tta_pkg::REG_PWM_FORWARD_SPAN: begin
					cfg_q.pwm_forward_span <= pwdata[tta_pkg::PWM_BITS-1:0];
				end
				tta_pkg::REG_PWM_REVERSE_SPAN: begin
					cfg_q.pwm_reverse_span <= pwdata[tta_pkg::PWM_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Read back; gains are sign extended.
	always_comb begin
		case (reg_idx)
			tta_pkg::REG_SURGE_GAIN_FIRST: begin
				prdata = {{(tta_pkg::DATA_BITS - tta_pkg::GAIN_BITS)
					{cfg_q.surge_gain_first[tta_pkg::GAIN_BITS-1]}}, cfg_q.surge_gain_first};
			end
			tta_pkg::REG_SURGE_GAIN_SECOND: begin
				prdata = {{(tta_pkg::DATA_BITS - tta_pkg::GAIN_BITS)
					{cfg_q.surge_gain_second[tta_pkg::GAIN_BITS-1]}}, cfg_q.surge_gain_second};
			end
			tta_pkg::REG_SWAY_GAIN: begin
				prdata = {{(tta_pkg::DATA_BITS - tta_pkg::GAIN_BITS)
					{cfg_q.sway_gain[tta_pkg::GAIN_BITS-1]}}, cfg_q.sway_gain};
			end
			tta_pkg::REG_YAW_GAIN: begin
				prdata = {{(tta_pkg::DATA_BITS - tta_pkg::GAIN_BITS)
					{cfg_q.yaw_gain[tta_pkg::GAIN_BITS-1]}}, cfg_q.yaw_gain};
			end
			tta_pkg::REG_DEAD_BAND: begin
				prdata = {{(tta_pkg::DATA_BITS - tta_pkg::DEAD_BITS){1'b0}}, cfg_q.dead_band};
			end
			tta_pkg::REG_PWM_CENTER: begin
				prdata = {{(tta_pkg::DATA_BITS - tta_pkg::PWM_BITS){1'b0}}, cfg_q.pwm_center};
			end
			tta_pkg::REG_PWM_FORWARD_SPAN: begin
				prdata = {{(tta_pkg::DATA_BITS - tta_pkg::PWM_BITS){1'b0}},
					cfg_q.pwm_forward_span};
			end
			tta_pkg::REG_PWM_REVERSE_SPAN: begin
				prdata = {{(tta_pkg::DATA_BITS - tta_pkg::PWM_BITS){1'b0}},
					cfg_q.pwm_reverse_span};
			end
			default: begin
				prdata = {tta_pkg::DATA_BITS{1'b0}};
			end
		endcase
	end

	// The pipeline advances unless a finished beat is held by the receiver.
	assign en           = !(out_valid_q && pwm_stall);
	assign sample_stall = !en;

	tta_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.cfg        (cfg_q),
		.valid_in   (sample_valid),
		.surge_in   (surge_axis),
		.sway_in    (sway_axis),
		.yaw_in     (yaw_axis),
		.valid_out  (front_valid),
		.thrust_out (thrust)
	);

	tta_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.cfg       (cfg_q),
		.valid_in  (front_valid),
		.thrust_in (thrust),
		.valid_out (scale_valid),
		.lanes_out (scale_lanes)
	);

	tta_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid_in  (scale_valid),
		.lanes_in  (scale_lanes),
		.valid_out (div_valid),
		.lanes_out (div_lanes)
	);

	// Offset from the center and saturate to the PWM range.
	always_comb begin
		for (int l = 0; l < tta_pkg::LANES; l++) begin
			if (div_lanes[l].neg) begin
				pwm_sum[l] = {1'b0, cfg_q.pwm_center} - {1'b0, div_lanes[l].quo};
				pwm_d[l]   = pwm_sum[l][tta_pkg::PWM_BITS] ?
					{tta_pkg::PWM_BITS{1'b0}} : pwm_sum[l][tta_pkg::PWM_BITS-1:0];
			end else begin
				pwm_sum[l] = {1'b0, cfg_q.pwm_center} + {1'b0, div_lanes[l].quo};
				pwm_d[l]   = pwm_sum[l][tta_pkg::PWM_BITS] ?
					tta_pkg::PWM_MAX : pwm_sum[l][tta_pkg::PWM_BITS-1:0];
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < tta_pkg::LANES; l++) begin
				pwm_q[l] <= pwm_d[l];
			end
		end
	end

	assign pwm_valid = out_valid_q;
	assign pwm_one   = pwm_q[0];
	assign pwm_two   = pwm_q[1];
	assign pwm_three = pwm_q[2];

endmodule
`default_nettype wire

/* verif/tb.sv */
`timescale 1ns / 1ps

module tb;

	import tta_pkg::*;

	typedef logic signed [AXIS_BITS-1:0] axis_t;

	// Three PWM values of one result beat.
	typedef struct packed {
		logic [PWM_BITS-1:0] p1;
		logic [PWM_BITS-1:0] p2;
		logic [PWM_BITS-1:0] p3;
	} pwm_trio_t;

	// One row of the directed table: either a register write or a sample beat.
	typedef struct packed {
		bit                      is_write;
		logic [REG_IDX_BITS-1:0] idx;
		logic [DATA_BITS-1:0]    wdata;
		axis_t                   surge;
		axis_t                   sway;
		axis_t                   yaw;
		bit                      known;
		pwm_trio_t               lit;
	} step_t;

	localparam int THRUST_FRAC = AXIS_BITS - 1 + GAIN_FRAC;
	localparam int PWM_TOP     = (1 << PWM_BITS) - 1;

	logic                 clk;
	logic                 arst_n;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [ADDR_BITS-1:0] paddr;
	logic [DATA_BITS-1:0] pwdata;
	logic [DATA_BITS-1:0] prdata;
	logic                 pready;
	logic                 sample_valid;
	logic                 sample_stall;
	axis_t                surge_axis;
	axis_t                sway_axis;
	axis_t                yaw_axis;
	logic                 pwm_valid;
	logic                 pwm_stall;
	logic [PWM_BITS-1:0]  pwm_one;
	logic [PWM_BITS-1:0]  pwm_two;
	logic [PWM_BITS-1:0]  pwm_three;

	cfg_t      shadow_cfg;
	pwm_trio_t pending_pwm[$];
	step_t     stim_table[$];
	int        mismatch_count;
	int        send_idle_pct;
	int        stall_pct;

	three_thruster_allocation_pwm dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.surge_axis   (surge_axis),
		.sway_axis    (sway_axis),
		.yaw_axis     (yaw_axis),
		.pwm_valid    (pwm_valid),
		.pwm_stall    (pwm_stall),
		.pwm_one      (pwm_one),
		.pwm_two      (pwm_two),
		.pwm_three    (pwm_three)
	);

	always #6 clk = ~clk;

	// Axis value after the dead band test; the test is on magnitude.
	function automatic longint dead_zone(input axis_t a);
		longint v;
		longint m;
		v = a;
		m = (v < 0) ? -v : v;
		return (m <= longint'(shadow_cfg.dead_band)) ? 0 : v;
	endfunction

	// Maps one thrust to PWM: center +/- round(span*|t|/den), then saturation.
	function automatic logic [PWM_BITS-1:0] thrust_to_pwm(input longint t, input longint den);
		longint span;
		longint num;
		longint q;
		longint r;
		span = (t >= 0) ? longint'(shadow_cfg.pwm_forward_span)
			: longint'(shadow_cfg.pwm_reverse_span);
		num = span * ((t < 0) ? -t : t);
		q = (2 * num + den) / (2 * den);
		r = (t >= 0) ? longint'(shadow_cfg.pwm_center) + q : longint'(shadow_cfg.pwm_center) - q;
		if (r < 0)
			r = 0;
		if (r > PWM_TOP)
			r = PWM_TOP;
		return r[PWM_BITS-1:0];
	endfunction

	// Expected PWM beat for one joystick sample under the current registers.
	function automatic pwm_trio_t allocate_pwm(input axis_t s, input axis_t w, input axis_t y);
		longint su;
		longint sw;
		longint ya;
		longint mix;
		longint t1;
		longint t2;
		longint t3;
		longint den;
		longint m;
		pwm_trio_t res;
		su = dead_zone(s);
		sw = dead_zone(w);
		ya = dead_zone(y);
		mix = sw * longint'(shadow_cfg.sway_gain) + ya * longint'(shadow_cfg.yaw_gain);
		t1 = su * longint'(shadow_cfg.surge_gain_first) + mix;
		t2 = su * longint'(shadow_cfg.surge_gain_second) - mix;
		t3 = sw * (64'sd1 << GAIN_FRAC);
		// Normalize by the largest magnitude only when it exceeds full scale.
		den = (t1 < 0) ? -t1 : t1;
		m = (t2 < 0) ? -t2 : t2;
		if (m > den)
			den = m;
		m = (t3 < 0) ? -t3 : t3;
		if (m > den)
			den = m;
		if (den <= (64'sd1 << THRUST_FRAC))
			den = 64'sd1 << THRUST_FRAC;
		res.p1 = thrust_to_pwm(t1, den);
		res.p2 = thrust_to_pwm(t2, den);
		res.p3 = thrust_to_pwm(t3, den);
		return res;
	endfunction

	function automatic void add_beat(input axis_t s, input axis_t w, input axis_t y);
		step_t row;
		row = '0;
		row.surge = s;
		row.sway = w;
		row.yaw = y;
		stim_table.push_back(row);
	endfunction

	function automatic void add_known(input axis_t s, input axis_t w, input axis_t y,
			input int p1, input int p2, input int p3);
		step_t row;
		row = '0;
		row.surge = s;
		row.sway = w;
		row.yaw = y;
		row.known = 1'b1;
		row.lit.p1 = p1[PWM_BITS-1:0];
		row.lit.p2 = p2[PWM_BITS-1:0];
		row.lit.p3 = p3[PWM_BITS-1:0];
		stim_table.push_back(row);
	endfunction

	function automatic void add_write(input logic [REG_IDX_BITS-1:0] idx, input int value);
		step_t row;
		row = '0;
		row.is_write = 1'b1;
		row.idx = idx;
		row.wdata = value;
		stim_table.push_back(row);
	endfunction

	// APB write: setup phase, access phase, then the bus idles and the shadow copy is updated.
	task automatic write_reg(input logic [REG_IDX_BITS-1:0] idx, input int value);
		logic [DATA_BITS-1:0] v;
		v = value;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_SURGE_GAIN_FIRST:  shadow_cfg.surge_gain_first = v[GAIN_BITS-1:0];
			REG_SURGE_GAIN_SECOND: shadow_cfg.surge_gain_second = v[GAIN_BITS-1:0];
			REG_SWAY_GAIN:         shadow_cfg.sway_gain = v[GAIN_BITS-1:0];
			REG_YAW_GAIN:          shadow_cfg.yaw_gain = v[GAIN_BITS-1:0];
			REG_DEAD_BAND:         shadow_cfg.dead_band = v[DEAD_BITS-1:0];
			REG_PWM_CENTER:        shadow_cfg.pwm_center = v[PWM_BITS-1:0];
			REG_PWM_FORWARD_SPAN:  shadow_cfg.pwm_forward_span = v[PWM_BITS-1:0];
			REG_PWM_REVERSE_SPAN:  shadow_cfg.pwm_reverse_span = v[PWM_BITS-1:0];
			default: ;
		endcase
	endtask

	// Drops the sample valid and waits until every expected beat has come back.
	task automatic wait_drained();
		sample_valid <= 1'b0;
		while (pending_pwm.size() != 0)
			@(posedge clk);
	endtask

	// Offers one sample beat, with an optional gap first, and records its expectation.
	// Each idle cycle is drawn on its own, so without stalls the idle share of cycles is send_idle_pct.
	task automatic send_beat(input axis_t s, input axis_t w, input axis_t y,
			input bit known, input pwm_trio_t lit);
		pwm_trio_t want;
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample_valid <= 1'b1;
		surge_axis <= s;
		sway_axis <= w;
		yaw_axis <= y;
		do
			@(posedge clk);
		while (!(sample_valid && !sample_stall));
		want = known ? lit : allocate_pwm(s, w, y);
		pending_pwm.push_back(want);
	endtask

	function automatic int pick_gain();
		logic signed [GAIN_BITS-1:0] g;
		logic [31:0] r;
		r = $urandom;
		g = r[GAIN_BITS-1:0];
		case ($urandom_range(4))
			0: return -32768;
			1: return 32767;
			2: return int'($urandom_range(12000)) - 6000;
			default: return int'(g);
		endcase
	endfunction

	function automatic int pick_pwm_reg();
		case ($urandom_range(5))
			0: return 0;
			1: return PWM_TOP;
			default: return $urandom_range(PWM_TOP);
		endcase
	endfunction

	function automatic int pick_dead_band();
		case ($urandom_range(6))
			0: return 0;
			1: return (1 << DEAD_BITS) - 1;
			2: return $urandom_range((1 << DEAD_BITS) - 1);
			default: return $urandom_range(4000);
		endcase
	endfunction

	// Random axis, biased toward the extremes and the dead band edges.
	function automatic axis_t pick_axis();
		int db;
		int v;
		logic [31:0] r;
		db = shadow_cfg.dead_band;
		r = $urandom;
		case ($urandom_range(9))
			0: v = -32768;
			1: v = 32767;
			2: v = 0;
			3: begin
				v = db + int'($urandom_range(2)) - 1;
				if ($urandom_range(1))
					v = -v;
			end
			4, 5: v = int'($urandom_range(4000)) - 2000;
			default: v = int'(r);
		endcase
		return v[AXIS_BITS-1:0];
	endfunction

	// Loads a whole register set: the reset values, or random ones with extremes.
	task automatic load_settings(input bit defaults);
		if (defaults) begin
			write_reg(REG_SURGE_GAIN_FIRST, int'(RST_SURGE_GAIN_FIRST));
			write_reg(REG_SURGE_GAIN_SECOND, int'(RST_SURGE_GAIN_SECOND));
			write_reg(REG_SWAY_GAIN, -3251);
			write_reg(REG_YAW_GAIN, int'(RST_YAW_GAIN));
			write_reg(REG_DEAD_BAND, int'(RST_DEAD_BAND));
			write_reg(REG_PWM_CENTER, int'(RST_PWM_CENTER));
			write_reg(REG_PWM_FORWARD_SPAN, int'(RST_PWM_FORWARD_SPAN));
			write_reg(REG_PWM_REVERSE_SPAN, int'(RST_PWM_REVERSE_SPAN));
		end else begin
			write_reg(REG_SURGE_GAIN_FIRST, pick_gain());
			write_reg(REG_SURGE_GAIN_SECOND, pick_gain());
			write_reg(REG_SWAY_GAIN, pick_gain());
			write_reg(REG_YAW_GAIN, pick_gain());
			write_reg(REG_DEAD_BAND, pick_dead_band());
			write_reg(REG_PWM_CENTER, pick_pwm_reg());
			write_reg(REG_PWM_FORWARD_SPAN, pick_pwm_reg());
			write_reg(REG_PWM_REVERSE_SPAN, pick_pwm_reg());
		end
	endtask

	// Result monitor: checks each accepted PWM beat against the oldest expectation.
	always @(posedge clk) begin : pwm_monitor
		pwm_trio_t want;
		if (arst_n && pwm_valid && !pwm_stall) begin
			if (pending_pwm.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected pwm beat %0d %0d %0d at %0t",
						pwm_one, pwm_two, pwm_three, $realtime);
			end else begin
				want = pending_pwm.pop_front();
				if (pwm_one !== want.p1 || pwm_two !== want.p2 || pwm_three !== want.p3) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("pwm mismatch at %0t: expected %0d %0d %0d, got %0d %0d %0d",
							$realtime, want.p1, want.p2, want.p3,
							pwm_one, pwm_two, pwm_three);
				end
			end
		end
		pwm_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
	end

	initial begin
		#5_000_000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin : stimulus
		step_t row;
		pwm_trio_t none;
		int per_batch;
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		sample_valid = 1'b0;
		surge_axis = '0;
		sway_axis = '0;
		yaw_axis = '0;
		pwm_stall = 1'b0;
		mismatch_count = 0;
		send_idle_pct = 0;
		stall_pct = 0;
		none = '0;
		per_batch = 222;

		shadow_cfg.surge_gain_first = RST_SURGE_GAIN_FIRST;
		shadow_cfg.surge_gain_second = RST_SURGE_GAIN_SECOND;
		shadow_cfg.sway_gain = RST_SWAY_GAIN;
		shadow_cfg.yaw_gain = RST_YAW_GAIN;
		shadow_cfg.dead_band = RST_DEAD_BAND;
		shadow_cfg.pwm_center = RST_PWM_CENTER;
		shadow_cfg.pwm_forward_span = RST_PWM_FORWARD_SPAN;
		shadow_cfg.pwm_reverse_span = RST_PWM_REVERSE_SPAN;

		// Directed table, starting from the reset values of the registers.
		add_known(0, 0, 0, 1500, 1500, 1500);
		// Axes exactly on the dead band edge are zeroed.
		add_known(1638, -1638, 1638, 1500, 1500, 1500);
		add_known(32767, 0, 0, 1900, 1900, 1500);
		// The most negative axis has magnitude of exactly full scale.
		add_known(-32768, 0, 0, 1300, 1300, 1500);
		add_beat(1639, -1639, 1639);
		add_beat(0, 32767, 0);
		add_beat(0, -32768, 0);
		add_beat(0, 0, 32767);
		add_beat(0, 0, -32768);
		add_beat(32767, 32767, 32767);
		add_beat(-32768, -32768, -32768);
		// Saturation at the top of the PWM range.
		add_write(REG_PWM_CENTER, PWM_TOP);
		add_write(REG_PWM_FORWARD_SPAN, PWM_TOP);
		add_write(REG_PWM_REVERSE_SPAN, 0);
		add_known(32767, 0, 0, PWM_TOP, PWM_TOP, PWM_TOP);
		add_known(-32768, 0, 0, PWM_TOP, PWM_TOP, PWM_TOP);
		// Saturation at zero.
		add_write(REG_PWM_CENTER, 0);
		add_write(REG_PWM_FORWARD_SPAN, 0);
		add_write(REG_PWM_REVERSE_SPAN, PWM_TOP);
		add_known(-32768, 0, 0, 0, 0, 0);
		add_known(32767, 0, 0, 0, 0, 0);
		// Extreme gains with the widest dead band, then none at all.
		add_write(REG_SURGE_GAIN_FIRST, -32768);
		add_write(REG_SURGE_GAIN_SECOND, 32767);
		add_write(REG_SWAY_GAIN, -32768);
		add_write(REG_YAW_GAIN, 32767);
		add_write(REG_DEAD_BAND, (1 << DEAD_BITS) - 1);
		add_write(REG_PWM_CENTER, 2048);
		add_write(REG_PWM_FORWARD_SPAN, PWM_TOP);
		add_known(32767, 32767, 32767, 2048, 2048, 2048);
		add_beat(-32768, -32768, -32768);
		add_write(REG_DEAD_BAND, 0);
		add_beat(1, -1, 1);
		add_beat(-32768, 32767, -32768);
		add_beat(12345, -23456, -11215);

		repeat (5)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 33;
		stall_pct = 59;
		for (int i = 0; i < stim_table.size(); i++) begin
			row = stim_table[i];
			if (row.is_write) begin
				wait_drained();
				write_reg(row.idx, int'(row.wdata));
			end else begin
				send_beat(row.surge, row.sway, row.yaw, row.known, row.lit);
			end
		end

		// Random part: three idling profiles, three register sets in each.
		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 33;
					stall_pct = 59;
				end
				1: begin
					send_idle_pct = 59;
					stall_pct = 33;
				end
				default: begin
					send_idle_pct = 0;
					stall_pct = 0;
				end
			endcase
			for (int b = 0; b < 3; b++) begin
				wait_drained();
				load_settings(b == 0);
				for (int n = 0; n < per_batch; n++)
					send_beat(pick_axis(), pick_axis(), pick_axis(), 1'b0, none);
			end
		end

		wait_drained();
		repeat (30)
			@(posedge clk);
		if (mismatch_count == 0 && pending_pwm.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
